>>> rtl/sbus_pkg.sv
`timescale 1ns / 1ps

package sbus_pkg;

  // Frame layout
  localparam int unsigned POS_WIDTH   = 5;
  localparam logic [POS_WIDTH-1:0] FLAG_POS = 5'd23;  // flag byte position
  localparam logic [POS_WIDTH-1:0] LAST_POS = 5'd24;  // end byte position
  localparam int unsigned DATA_BYTES  = 22;
  localparam int unsigned DATA_BITS   = DATA_BYTES * 8;

  // Channels
  localparam int unsigned CH_WIDTH    = 11;
  localparam int unsigned IDX_WIDTH   = 5;
  localparam logic [IDX_WIDTH-1:0] NUM_PROP   = 5'd16;
  localparam logic [IDX_WIDTH-1:0] DIG_CHAN_A = 5'd16;
  localparam logic [IDX_WIDTH-1:0] LAST_CHAN  = 5'd17;
  localparam logic [CH_WIDTH-1:0]  DIGITAL_ON = 11'h7FF;

  // Flag byte bits
  localparam int unsigned FLAG_DIG_A    = 0;
  localparam int unsigned FLAG_DIG_B    = 1;
  localparam int unsigned FLAG_LOST     = 2;
  localparam int unsigned FLAG_FAILSAFE = 3;

  // Result counters as seen on the port
  localparam int unsigned OUT_COUNT_WIDTH = 32;

  // Configuration registers
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_BYTE   = 1'b1;
  localparam logic [7:0] START_BYTE_RESET = 8'h0F;
  localparam logic [7:0] END_BYTE_RESET   = 8'h00;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_BAD,
    ST_GOOD
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic store;       // take a frame byte at the current position
    logic sync_err;    // byte dropped while hunting
    logic frame_bad;   // end byte mismatch
    logic frame_good;  // end byte ok, start result sequence
    logic advance;     // result transfer done, move to next channel
    logic err_view;    // result shown is the error result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic pos_last;
    logic start_match;
    logic end_match;
    logic chan_last;
  } stat_t;

endpackage

>>> rtl/sbus_if.sv
`timescale 1ns / 1ps

// Received byte stream
interface sbus_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded result stream
interface sbus_result_if;
  import sbus_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [IDX_WIDTH-1:0]       channel_index;
  logic [CH_WIDTH-1:0]        channel_value;
  logic                       failsafe;
  logic                       frame_lost;
  logic                       last;
  logic [OUT_COUNT_WIDTH-1:0] good_count;
  logic [OUT_COUNT_WIDTH-1:0] lost_count;
  logic [OUT_COUNT_WIDTH-1:0] error_count;

  modport source (
    output valid, output status, output channel_index, output channel_value,
    output failsafe, output frame_lost, output last,
    output good_count, output lost_count, output error_count,
    input ready
  );
  modport sink (
    input valid, input status, input channel_index, input channel_value,
    input failsafe, input frame_lost, input last,
    input good_count, input lost_count, input error_count,
    output ready
  );
endinterface

>>> rtl/sbus_frame_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Transfer
// rx        in   rx_byte                                          valid && ready
// result    out  status, channel_index, channel_value, failsafe,  valid && ready
//                frame_lost, last, good/lost/error_count
// cfg       in   cfg_index, cfg_data                              cfg_we
//
// Bytes are taken one per cycle while a frame is being received.
// The end byte of a good frame starts 18 result transfers, one channel per
// transfer from the frame shift line; a bad end byte gives one. rx.ready is
// low until the last of them completes.
// Synchronous active-high reset clears position, channel, failsafe flag and counters and presets registers.
// A stall on result.ready holds the current result and the input side.
module sbus_frame_decoder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sbus_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sbus_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  sbus_byte_if.sink                            rx,
  sbus_result_if.source                        result
);
  import sbus_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  sbus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Frame store, decode and counters
  sbus_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx.rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .status        (result.status),
    .channel_index (result.channel_index),
    .channel_value (result.channel_value),
    .failsafe      (result.failsafe),
    .frame_lost    (result.frame_lost),
    .last          (result.last),
    .good_count    (result.good_count),
    .lost_count    (result.lost_count),
    .error_count   (result.error_count)
  );

endmodule

>>> rtl/sbus_ctrl.sv
`timescale 1ns / 1ps

module sbus_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sbus_pkg::stat_t stat,
  output sbus_pkg::cmd_t  cmd
);
  import sbus_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_RECV: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.pos_zero && !stat.start_match) begin
            cmd.sync_err = 1'b1;
          end else if (!stat.pos_last) begin
            cmd.store = 1'b1;
          end else if (stat.end_match) begin
            cmd.frame_good = 1'b1;
            state_next     = ST_GOOD;
          end else begin
            cmd.frame_bad = 1'b1;
            state_next    = ST_BAD;
          end
        end
      end
      ST_BAD: begin
        out_valid    = 1'b1;
        cmd.err_view = 1'b1;
        if (out_ready) begin
          state_next = ST_RECV;
        end
      end
      ST_GOOD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (stat.chan_last) begin
            state_next = ST_RECV;
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  // Input and output sides never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and result handshakes open together");

  // A good end byte always starts the result sequence
  a_good_enters_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_good |=> (state == ST_GOOD))
    else $error("good frame did not start result sequence");

  // Last channel transfer returns to receiving
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GOOD && out_ready && stat.chan_last) |=> (state == ST_RECV))
    else $error("result sequence did not end after last channel");

endmodule

>>> rtl/sbus_dp.sv
`timescale 1ns / 1ps

module sbus_dp #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [sbus_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [sbus_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic [7:0]                              rx_byte,
  input  sbus_pkg::cmd_t                          cmd,
  output sbus_pkg::stat_t                         stat,
  output logic                                    status,
  output logic [sbus_pkg::IDX_WIDTH-1:0]          channel_index,
  output logic [sbus_pkg::CH_WIDTH-1:0]           channel_value,
  output logic                                    failsafe,
  output logic                                    frame_lost,
  output logic                                    last,
  output logic [sbus_pkg::OUT_COUNT_WIDTH-1:0]    good_count,
  output logic [sbus_pkg::OUT_COUNT_WIDTH-1:0]    lost_count,
  output logic [sbus_pkg::OUT_COUNT_WIDTH-1:0]    error_count
);
  import sbus_pkg::*;

  logic [7:0]             start_byte;
  logic [7:0]             end_byte;
  logic [POS_WIDTH-1:0]   byte_position;
  logic [DATA_BITS-1:0]   frame_data;    // data bytes, LSB first, shifted line
  logic [7:0]             flag_byte;
  logic [IDX_WIDTH-1:0]   chan;
  logic                   failsafe_flag;
  logic [COUNT_WIDTH-1:0] good_frames;
  logic [COUNT_WIDTH-1:0] lost_frames;
  logic [COUNT_WIDTH-1:0] error_frames;
  logic                   dig_bit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      end_byte   <= END_BYTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Byte position and channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      chan          <= '0;
    end else begin
      if (cmd.store) begin
        byte_position <= byte_position + 1'b1;
      end else if (cmd.frame_good || cmd.frame_bad) begin
        byte_position <= '0;
      end
      if (cmd.frame_good) begin
        chan <= '0;
      end else if (cmd.advance) begin
        chan <= chan + 1'b1;
      end
    end
  end

  // Frame store: data bytes shift in from the top, channels shift out at the bottom
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (byte_position == FLAG_POS) begin
        flag_byte <= rx_byte;
      end else begin
        frame_data <= {rx_byte, frame_data[DATA_BITS-1:8]};
      end
    end else if (cmd.advance) begin
      frame_data <= frame_data >> CH_WIDTH;
    end
  end

  // Flags and saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_flag <= 1'b0;
      good_frames   <= '0;
      lost_frames   <= '0;
      error_frames  <= '0;
    end else begin
      if (cmd.sync_err || cmd.frame_bad) begin
        if (error_frames != '1) begin
          error_frames <= error_frames + 1'b1;
        end
      end
      if (cmd.frame_good) begin
        failsafe_flag <= flag_byte[FLAG_FAILSAFE];
        if (good_frames != '1) begin
          good_frames <= good_frames + 1'b1;
        end
        if (flag_byte[FLAG_LOST] && (lost_frames != '1)) begin
          lost_frames <= lost_frames + 1'b1;
        end
      end
    end
  end

  // Status to controller
  always_comb begin
    stat.pos_zero    = (byte_position == '0);
    stat.pos_last    = (byte_position == LAST_POS);
    stat.start_match = (rx_byte == start_byte);
    stat.end_match   = (rx_byte == end_byte);
    stat.chan_last   = (chan == LAST_CHAN);
  end

  // Result payload
  assign dig_bit = (chan == DIG_CHAN_A) ? flag_byte[FLAG_DIG_A] : flag_byte[FLAG_DIG_B];

  always_comb begin
    if (cmd.err_view) begin
      status        = 1'b1;
      channel_index = '0;
      channel_value = '0;
      frame_lost    = 1'b0;
      last          = 1'b1;
    end else begin
      status        = 1'b0;
      channel_index = chan;
      frame_lost    = flag_byte[FLAG_LOST];
      last          = (chan == LAST_CHAN);
      if (chan < NUM_PROP) begin
        channel_value = frame_data[CH_WIDTH-1:0];
      end else begin
        channel_value = dig_bit ? DIGITAL_ON : '0;
      end
    end
  end

  assign failsafe    = failsafe_flag;
  assign good_count  = OUT_COUNT_WIDTH'(good_frames);
  assign lost_count  = OUT_COUNT_WIDTH'(lost_frames);
  assign error_count = OUT_COUNT_WIDTH'(error_frames);

  // Position never runs past the end byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS)
    else $error("byte position out of frame");

  // At most one byte action or channel advance per cycle
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.store, cmd.sync_err, cmd.frame_bad, cmd.frame_good, cmd.advance}))
    else $error("conflicting datapath commands");

  // A good frame rewinds position and channel
  a_good_rewind: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_good |=> (byte_position == '0 && chan == '0))
    else $error("frame end did not rewind counters");

endmodule

>>> verif/tb_sbus_frame_decoder.sv
`timescale 1ns / 1ps

module tb_sbus_frame_decoder;
  import sbus_pkg::*;

  localparam int unsigned RESET_CYCLES     = 3;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned TAIL_CYCLES      = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned FRAME_BYTES      = 25;
  localparam int unsigned STORE_BYTES      = 24;
  localparam int unsigned PHASE_BYTES      = 70;
  localparam logic        STATUS_CHANNEL   = 1'b0;
  localparam logic        STATUS_REJECT    = 1'b1;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_t;

  typedef struct packed {
    logic                       status;
    logic [IDX_WIDTH-1:0]       channel_index;
    logic [CH_WIDTH-1:0]        channel_value;
    logic                       failsafe;
    logic                       frame_lost;
    logic                       last;
    logic [OUT_COUNT_WIDTH-1:0] good_count;
    logic [OUT_COUNT_WIDTH-1:0] lost_count;
    logic [OUT_COUNT_WIDTH-1:0] error_count;
  } chan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  sbus_byte_if   rx_if ();
  sbus_result_if result_if ();

  sbus_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_if),
    .result    (result_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder mirror: registers, frame store, flags and counters
  logic [7:0]                 model_start;
  logic [7:0]                 model_end;
  logic [POS_WIDTH-1:0]       model_pos;
  logic [7:0]                 model_store [STORE_BYTES];
  logic                       model_failsafe;
  logic [OUT_COUNT_WIDTH-1:0] model_good;
  logic [OUT_COUNT_WIDTH-1:0] model_lost;
  logic [OUT_COUNT_WIDTH-1:0] model_errors;

  chan_result_t expected_results [$];
  logic [7:0]   pending_bytes [$];

  // Stimulus side view of the registers
  logic [7:0] stim_start;
  logic [7:0] stim_end;

  int mismatch_count   = 0;
  int results_checked  = 0;
  int bytes_taken      = 0;
  int good_frames_seen = 0;
  int rejected_frames  = 0;
  int sync_drops       = 0;
  int reg_settings     = 1;
  int frame_bytes_sent = 0;
  int cycle_count      = 0;

  // Long receiver hold-off handshake between stimulus and receiver
  int hold_requests = 0;
  int holds_served  = 0;

  function automatic logic [OUT_COUNT_WIDTH-1:0] sat_inc(
    input logic [OUT_COUNT_WIDTH-1:0] c
  );
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic chan_result_t make_result(
    input logic                 status,
    input logic [IDX_WIDTH-1:0] idx,
    input logic [CH_WIDTH-1:0]  value,
    input logic                 lost,
    input logic                 last
  );
    chan_result_t r;
    r.status        = status;
    r.channel_index = idx;
    r.channel_value = value;
    r.failsafe      = model_failsafe;
    r.frame_lost    = lost;
    r.last          = last;
    r.good_count    = model_good;
    r.lost_count    = model_lost;
    r.error_count   = model_errors;
    return r;
  endfunction

  // Advance the mirror by one received byte, queue what it yields
  task automatic decode_byte(input logic [7:0] b);
    logic [DATA_BITS-1:0] payload;
    logic [7:0]           flags;
    logic                 lost;
    logic [CH_WIDTH-1:0]  value;
    if (model_pos == 0 && b != model_start) begin
      model_errors = sat_inc(model_errors);
      sync_drops++;
      return;
    end
    if (model_pos < STORE_BYTES) begin
      model_store[model_pos] = b;
      model_pos++;
      return;
    end
    // end byte
    model_pos = '0;
    if (b != model_end) begin
      model_errors = sat_inc(model_errors);
      rejected_frames++;
      expected_results.push_back(make_result(STATUS_REJECT, '0, '0, 1'b0, 1'b1));
      return;
    end
    good_frames_seen++;
    model_good     = sat_inc(model_good);
    flags          = model_store[FLAG_POS];
    model_failsafe = flags[FLAG_FAILSAFE];
    lost           = flags[FLAG_LOST];
    if (lost)
      model_lost = sat_inc(model_lost);
    // proportional channels are packed LSB first from byte 1 on
    for (int i = 0; i < DATA_BYTES; i++)
      payload[8*i +: 8] = model_store[1 + i];
    for (int k = 0; k <= LAST_CHAN; k++) begin
      if (k < NUM_PROP)
        value = payload[CH_WIDTH*k +: CH_WIDTH];
      else if (k == DIG_CHAN_A)
        value = flags[FLAG_DIG_A] ? DIGITAL_ON : '0;
      else
        value = flags[FLAG_DIG_B] ? DIGITAL_ON : '0;
      expected_results.push_back(make_result(STATUS_CHANNEL, IDX_WIDTH'(k), value, lost,
                                             k == LAST_CHAN));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t result %0d: %s got %0d want %0d", $realtime, results_checked,
             what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // Predict on every byte transfer, check every result transfer
  always @(posedge clk) begin : scoreboard
    chan_result_t want;
    if (rst) begin
      model_start    = START_BYTE_RESET;
      model_end      = END_BYTE_RESET;
      model_pos      = '0;
      model_failsafe = 1'b0;
      model_good     = '0;
      model_lost     = '0;
      model_errors   = '0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_taken++;
        decode_byte(rx_if.rx_byte);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_BYTE: model_start = cfg_data;
          REG_END_BYTE:   model_end   = cfg_data;
          default: ;
        endcase
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, channel", 32'(result_if.channel_index), 0);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(result_if.status), 32'(want.status));
          compare_field("channel_index", 32'(result_if.channel_index),
                        32'(want.channel_index));
          compare_field("channel_value", 32'(result_if.channel_value),
                        32'(want.channel_value));
          compare_field("failsafe", 32'(result_if.failsafe), 32'(want.failsafe));
          compare_field("frame_lost", 32'(result_if.frame_lost), 32'(want.frame_lost));
          compare_field("last", 32'(result_if.last), 32'(want.last));
          compare_field("good_count",    result_if.good_count,    want.good_count);
          compare_field("lost_count",    result_if.lost_count,    want.lost_count);
          compare_field("error_count",   result_if.error_count,   want.error_count);
        end
        results_checked++;
      end
    end
  end

  // Byte driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
      burst_left  = $urandom_range(1, 40);
      gap_left    = 0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (gap_left != 0 || pending_bytes.size() == 0) begin
        rx_if.valid <= 1'b0;
        if (gap_left != 0)
          gap_left--;
      end else begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: rotating stall pattern, plus a long hold-off on request
  logic [15:0] stall_pattern = '0;
  logic [3:0]  pattern_step  = '0;
  int          pattern_age   = 0;
  int          hold_left     = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pattern = '0;
          1:       stall_pattern = 16'($urandom & $urandom);
          2:       stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom);
        endcase
      end
      pattern_age--;
      result_if.ready <= !stall_pattern[pattern_step];
      pattern_step++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_BYTE)
      stim_start = value;
    else
      stim_end = value;
  endtask

  // Hold the sender back until every expected result has come out
  task automatic wait_idle();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((pending_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered, count", expected_results.size(), 0);
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_frame(input fill_t fill, input logic [7:0] flags,
                             input logic [7:0] end_value, output logic [7:0] f [FRAME_BYTES]);
    f[0] = stim_start;
    for (int i = 1; i <= DATA_BYTES; i++) begin
      case (fill)
        FILL_ZERO: f[i] = 8'h00;
        FILL_ONES: f[i] = 8'hFF;
        default:   f[i] = 8'($urandom);
      endcase
    end
    f[FLAG_POS] = flags;
    f[LAST_POS] = end_value;
  endtask

  task automatic push_frame_bytes(input logic [7:0] f [FRAME_BYTES], input int first,
                                  input int count);
    for (int i = first; i < first + count; i++)
      pending_bytes.push_back(f[i]);
    frame_bytes_sent += count;
  endtask

  // Line noise while hunting: never the start byte, so framing stays aligned
  task automatic push_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (b == stim_start)
        b = ~b;
      pending_bytes.push_back(b);
    end
  endtask

  task automatic push_random_frame();
    logic [7:0] f [FRAME_BYTES];
    fill_t      fill;
    logic [7:0] end_value;
    case ($urandom_range(0, 19))
      0:       fill = FILL_ZERO;
      1:       fill = FILL_ONES;
      default: fill = FILL_RANDOM;
    endcase
    end_value = ($urandom_range(0, 99) < 85) ? stim_end
                                             : stim_end ^ 8'($urandom_range(1, 255));
    if ($urandom_range(0, 4) == 0)
      push_noise($urandom_range(1, 3));
    build_frame(fill, 8'($urandom), end_value, f);
    push_frame_bytes(f, 0, FRAME_BYTES);
  endtask

  initial begin
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] phase_start [5];
    logic [7:0] phase_end [5];
    int         phase_mark;

    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = 8'h00;
    result_if.ready = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_START_BYTE;
    cfg_data        = 8'h00;
    stim_start      = START_BYTE_RESET;
    stim_end        = END_BYTE_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sync loss, full-scale good frame with all flags, bad end byte
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    build_frame(FILL_ONES, 8'h0F, stim_end, f);
    push_frame_bytes(f, 0, FRAME_BYTES);
    build_frame(FILL_ZERO, 8'h00, 8'hFF, f);
    push_frame_bytes(f, 0, FRAME_BYTES);
    wait_idle();

    // Top extremes of both registers, all-zero frame clears failsafe
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'hFF);
    reg_settings++;
    pending_bytes.push_back(8'h00);
    build_frame(FILL_ZERO, 8'h00, 8'hFF, f);
    push_frame_bytes(f, 0, FRAME_BYTES);

    // Registers changed in the middle of a frame apply to the next byte
    build_frame(FILL_RANDOM, 8'h04, 8'h00, f);
    push_frame_bytes(f, 0, 12);
    wait_idle();
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'h00);
    reg_settings++;
    push_frame_bytes(f, 12, FRAME_BYTES - 12);
    wait_idle();

    // Random phases, each with its own register setting
    phase_start = '{START_BYTE_RESET, 8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
    phase_end   = '{END_BYTE_RESET, 8'h00, 8'($urandom), 8'hFF, 8'($urandom)};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_START_BYTE, phase_start[p]);
      write_reg(REG_END_BYTE, phase_end[p]);
      reg_settings++;
      // one phase runs against a receiver that holds off for a long stretch
      if (p == 1)
        hold_requests++;
      phase_mark = frame_bytes_sent;
      while (frame_bytes_sent - phase_mark < PHASE_BYTES)
        push_random_frame();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d byte transfers: %0d good frames, %0d rejected frames, %0d dropped",
             bytes_taken, good_frames_seen, rejected_frames, sync_drops);
    $display("%0d result transfers checked across %0d register settings in %0d cycles",
             results_checked, reg_settings, cycle_count);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
